### hdl/bsce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsce_pkg
// Shared types, codes and helpers of the bouncing sprite collision engine.
// ----------------------------------------------------------------------------
package bsce_pkg;

    localparam int FIELD_W     = 12;
    localparam int VEL_W       = 7;
    localparam int DIAM_W      = 7;
    localparam int RAD_W       = DIAM_W - 1;
    localparam int SLOT_W      = 3;
    localparam int OUT_COORD_W = 12;
    localparam int CFG_ADDR_W  = 1;
    localparam int HIT_CNT_W   = 5;

    localparam logic [HIT_CNT_W-1:0] HIT_LIMIT = 5'd28;

    localparam logic [FIELD_W-1:0] FIELD_WIDTH_RST  = 12'd640;
    localparam logic [FIELD_W-1:0] FIELD_HEIGHT_RST = 12'd480;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIELD_HEIGHT = 1'b1;

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MV_RD,
        ST_MV_ADD,
        ST_MV_BNC,
        ST_PR_RD,
        ST_PR_EDGE,
        ST_PR_TEST,
        ST_CLOSE
    } state_t;

    typedef struct packed {
        logic load_wr;
        logic mv_add;
        logic mv_wr;
        logic pr_edge;
        logic out_hit;
        logic out_close;
    } cmd_t;

    typedef struct packed {
        logic pair_hit;
        logic out_free;
    } stat_t;

    // negate with saturation, the most negative value turns into the largest
    function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] n;
        n = (v == VEL_MIN) ? VEL_MAX : -v;
        return n;
    endfunction

endpackage

### hdl/bsce_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsce_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bsce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### hdl/bsce_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsce_ctrl
// Sequencer: loads, the per-sprite move walk, the pair walk and the closing word.
// ----------------------------------------------------------------------------
module bsce_ctrl import bsce_pkg::*; #(
    parameter int SPRITE_COUNT = 8,
    localparam int IDX_W = $clog2(SPRITE_COUNT)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_op,
    output logic             in_ready,
    input  stat_t            stat,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] idx_a,
    output logic [IDX_W-1:0] idx_b
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SPRITE_COUNT - 1);
    localparam logic [IDX_W-1:0] IDX_PENULT = IDX_W'(SPRITE_COUNT - 2);

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       i_reg, i_next;
    logic [IDX_W-1:0]       j_reg, j_next;
    logic [HIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   emit;

    // a hit is sent only below the limit and only when the output slot is free
    assign emit = stat.pair_hit && (cnt_reg < HIT_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_op == OP_TICK))
                begin
                    state_next = ST_MV_RD;
                    i_next     = '0;
                    cnt_next   = '0;
                end
            end
            ST_MV_RD:
            begin
                state_next = ST_MV_ADD;
            end
            ST_MV_ADD:
            begin
                state_next = ST_MV_BNC;
            end
            ST_MV_BNC:
            begin
                if (i_reg == IDX_LAST)
                begin
                    state_next = ST_PR_RD;
                    i_next     = '0;
                    j_next     = IDX_W'(1);
                end
                else
                begin
                    state_next = ST_MV_RD;
                    i_next     = i_reg + IDX_W'(1);
                end
            end
            ST_PR_RD:
            begin
                state_next = ST_PR_EDGE;
            end
            ST_PR_EDGE:
            begin
                state_next = ST_PR_TEST;
            end
            ST_PR_TEST:
            begin
                if (!emit || stat.out_free)
                begin
                    if (emit)
                    begin
                        cnt_next = cnt_reg + HIT_CNT_W'(1);
                    end
                    if (j_reg == IDX_LAST)
                    begin
                        if (i_reg == IDX_PENULT)
                        begin
                            state_next = ST_CLOSE;
                        end
                        else
                        begin
                            state_next = ST_PR_RD;
                            i_next     = i_reg + IDX_W'(1);
                            j_next     = i_reg + IDX_W'(2);
                        end
                    end
                    else
                    begin
                        state_next = ST_PR_RD;
                        j_next     = j_reg + IDX_W'(1);
                    end
                end
            end
            ST_CLOSE:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_wr = in_valid && (in_op == OP_LOAD);
            end
            ST_MV_ADD:
            begin
                cmd.mv_add = 1'b1;
            end
            ST_MV_BNC:
            begin
                cmd.mv_wr = 1'b1;
            end
            ST_PR_EDGE:
            begin
                cmd.pr_edge = 1'b1;
            end
            ST_PR_TEST:
            begin
                cmd.out_hit = emit && stat.out_free;
            end
            ST_CLOSE:
            begin
                cmd.out_close = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign idx_a = i_reg;
    assign idx_b = j_reg;

endmodule

### hdl/bsce_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsce_dpath
// Sprite table, move and bounce unit, box overlap test and output register.
// ----------------------------------------------------------------------------
module bsce_dpath import bsce_pkg::*; #(
    parameter int SPRITE_COUNT = 8,
    parameter int COORD_BITS = 12,
    localparam int IDX_W = $clog2(SPRITE_COUNT)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [FIELD_W-1:0]      cfg_wdata,
    input  logic [SLOT_W-1:0]       in_slot,
    input  logic [FIELD_W-1:0]      in_pos_x,
    input  logic [FIELD_W-1:0]      in_pos_y,
    input  logic signed [VEL_W-1:0] in_vel_x,
    input  logic signed [VEL_W-1:0] in_vel_y,
    input  logic [DIAM_W-1:0]       in_diameter,
    input  logic                    in_enable,
    input  cmd_t                    cmd,
    input  logic [IDX_W-1:0]        idx_a,
    input  logic [IDX_W-1:0]        idx_b,
    output stat_t                   stat,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_hit,
    output logic [SLOT_W-1:0]       out_first_slot,
    output logic [SLOT_W-1:0]       out_second_slot,
    output logic [OUT_COORD_W-1:0]  out_box_left,
    output logic [OUT_COORD_W-1:0]  out_box_right,
    output logic [OUT_COORD_W-1:0]  out_box_top,
    output logic [OUT_COORD_W-1:0]  out_box_bottom,
    output logic                    out_last
);

    localparam int CB    = COORD_BITS;
    localparam int ES    = CB + 2;
    localparam int AW    = ((CB > FIELD_W) ? CB : FIELD_W) + 1;
    localparam int WW    = 2 * CB + 2 * VEL_W + DIAM_W;
    localparam int X_LO  = 0;
    localparam int Y_LO  = CB;
    localparam int VX_LO = 2 * CB;
    localparam int VY_LO = 2 * CB + VEL_W;
    localparam int D_LO  = 2 * CB + 2 * VEL_W;

    function automatic logic [CB-1:0] sat_edge(input logic signed [ES-1:0] v);
        logic [CB-1:0] s;
        s = v[ES-1] ? '0 : (v[CB] ? '1 : v[CB-1:0]);
        return s;
    endfunction

    // low wall first, then the far wall with the updated position
    function automatic logic [VEL_W+CB-1:0] bounce(
        input logic [CB-1:0]            p,
        input logic signed [VEL_W-1:0]  v,
        input logic [RAD_W-1:0]         r,
        input logic [FIELD_W-1:0]       lim
    );
        logic                       low;
        logic                       high;
        logic [CB-1:0]              p1;
        logic [CB-1:0]              p2;
        logic [CB-1:0]              hv_sat;
        logic signed [VEL_W-1:0]    v1;
        logic signed [VEL_W-1:0]    v2;
        logic [AW-1:0]              up;
        logic signed [AW:0]         hv;
        low    = (p <= CB'(r));
        p1     = low ? CB'(r) : p;
        v1     = low ? neg_vel(v) : v;
        up     = AW'(p1) + AW'(r);
        high   = (up >= AW'(lim));
        hv     = signed'((AW + 1)'(lim)) - signed'((AW + 1)'(r));
        hv_sat = hv[AW] ? '0 : ((|(hv[AW-1:0] >> CB)) ? '1 : hv[CB-1:0]);
        p2     = high ? hv_sat : p1;
        v2     = high ? neg_vel(v1) : v1;
        return {v2, p2};
    endfunction

    logic [FIELD_W-1:0]         width_reg;
    logic [FIELD_W-1:0]         height_reg;
    logic [SPRITE_COUNT-1:0]    valid_reg;

    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [WW-1:0]              ram_wdata;
    logic [WW-1:0]              rd_a;
    logic [WW-1:0]              rd_b;

    logic                       load_ok;
    logic [CB-1:0]              load_x;
    logic [CB-1:0]              load_y;

    logic [CB-1:0]              a_x, a_y, b_x, b_y;
    logic signed [VEL_W-1:0]    a_vx, a_vy;
    logic [DIAM_W-1:0]          a_d, b_d;
    logic [RAD_W-1:0]           a_r, b_r;

    logic signed [ES-1:0]       sum_x, sum_y;
    logic [CB-1:0]              mx_reg, my_reg;
    logic [VEL_W+CB-1:0]        bx, by;

    logic signed [ES-1:0]       al_reg, ar_reg, at_reg, ab_reg;
    logic signed [ES-1:0]       bl_reg, br_reg, bt_reg, bb_reg;
    logic                       pair_ok_reg;
    logic                       overlap;
    logic signed [ES-1:0]       left_s, right_s, top_s, bottom_s;

    logic                       out_valid_reg;
    logic                       hit_reg;
    logic                       last_reg;
    logic [SLOT_W-1:0]          first_reg, second_reg;
    logic [OUT_COORD_W-1:0]     left_reg, right_reg, top_reg, bottom_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FIELD_WIDTH_RST;
            height_reg <= FIELD_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_FIELD_WIDTH)
            begin
                width_reg <= cfg_wdata;
            end
            if (cfg_addr == CFG_FIELD_HEIGHT)
            begin
                height_reg <= cfg_wdata;
            end
        end
    end

    // load path
    assign load_ok = cmd.load_wr && (32'(in_slot) < SPRITE_COUNT);
    assign load_x  = (|(in_pos_x >> CB)) ? '1 : CB'(in_pos_x);
    assign load_y  = (|(in_pos_y >> CB)) ? '1 : CB'(in_pos_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load_ok)
        begin
            valid_reg[IDX_W'(in_slot)] <= in_enable;
        end
    end

    // table fields
    assign a_x  = rd_a[X_LO +: CB];
    assign a_y  = rd_a[Y_LO +: CB];
    assign a_vx = rd_a[VX_LO +: VEL_W];
    assign a_vy = rd_a[VY_LO +: VEL_W];
    assign a_d  = rd_a[D_LO +: DIAM_W];
    assign a_r  = a_d[DIAM_W-1:1];
    assign b_x  = rd_b[X_LO +: CB];
    assign b_y  = rd_b[Y_LO +: CB];
    assign b_d  = rd_b[D_LO +: DIAM_W];
    assign b_r  = b_d[DIAM_W-1:1];

    // move step
    assign sum_x = signed'({2'b00, a_x}) + {{(ES-VEL_W){a_vx[VEL_W-1]}}, a_vx};
    assign sum_y = signed'({2'b00, a_y}) + {{(ES-VEL_W){a_vy[VEL_W-1]}}, a_vy};

    always_ff @(posedge clk)
    begin
        if (cmd.mv_add)
        begin
            mx_reg <= sat_edge(sum_x);
            my_reg <= sat_edge(sum_y);
        end
    end

    assign bx = bounce(mx_reg, a_vx, a_r, width_reg);
    assign by = bounce(my_reg, a_vy, a_r, height_reg);

    always_comb
    begin
        if (cmd.load_wr)
        begin
            ram_we    = load_ok;
            ram_waddr = IDX_W'(in_slot);
            ram_wdata = {in_diameter, in_vel_y, in_vel_x, load_y, load_x};
        end
        else
        begin
            ram_we    = cmd.mv_wr && valid_reg[idx_a];
            ram_waddr = idx_a;
            ram_wdata = {a_d, by[VEL_W+CB-1:CB], bx[VEL_W+CB-1:CB],
                         by[CB-1:0], bx[CB-1:0]};
        end
    end

    bsce_ram #(
        .WIDTH (WW),
        .DEPTH (SPRITE_COUNT)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (idx_a),
        .rdata_a (rd_a),
        .raddr_b (idx_b),
        .rdata_b (rd_b)
    );

    // bounding box edges of both sprites
    always_ff @(posedge clk)
    begin
        if (cmd.pr_edge)
        begin
            al_reg      <= signed'({2'b00, a_x}) - signed'(ES'(a_r));
            ar_reg      <= signed'({2'b00, a_x}) + signed'(ES'(a_r));
            at_reg      <= signed'({2'b00, a_y}) - signed'(ES'(a_r));
            ab_reg      <= signed'({2'b00, a_y}) + signed'(ES'(a_r));
            bl_reg      <= signed'({2'b00, b_x}) - signed'(ES'(b_r));
            br_reg      <= signed'({2'b00, b_x}) + signed'(ES'(b_r));
            bt_reg      <= signed'({2'b00, b_y}) - signed'(ES'(b_r));
            bb_reg      <= signed'({2'b00, b_y}) + signed'(ES'(b_r));
            pair_ok_reg <= valid_reg[idx_a] && valid_reg[idx_b];
        end
    end

    // touching edges count as overlap
    assign overlap = !((al_reg > br_reg) || (ar_reg < bl_reg) ||
                       (at_reg > bb_reg) || (ab_reg < bt_reg));

    assign left_s   = (al_reg > bl_reg) ? al_reg : bl_reg;
    assign right_s  = (ar_reg < br_reg) ? ar_reg : br_reg;
    assign top_s    = (at_reg > bt_reg) ? at_reg : bt_reg;
    assign bottom_s = (ab_reg < bb_reg) ? ab_reg : bb_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_hit || cmd.out_close)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_hit)
        begin
            hit_reg    <= 1'b1;
            last_reg   <= 1'b0;
            first_reg  <= SLOT_W'(idx_a);
            second_reg <= SLOT_W'(idx_b);
            left_reg   <= OUT_COORD_W'(sat_edge(left_s));
            right_reg  <= OUT_COORD_W'(sat_edge(right_s));
            top_reg    <= OUT_COORD_W'(sat_edge(top_s));
            bottom_reg <= OUT_COORD_W'(sat_edge(bottom_s));
        end
        else if (cmd.out_close)
        begin
            hit_reg    <= 1'b0;
            last_reg   <= 1'b1;
            first_reg  <= '0;
            second_reg <= '0;
            left_reg   <= '0;
            right_reg  <= '0;
            top_reg    <= '0;
            bottom_reg <= '0;
        end
    end

    assign stat.pair_hit = pair_ok_reg && overlap;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_hit         = hit_reg;
    assign out_last        = last_reg;
    assign out_first_slot  = first_reg;
    assign out_second_slot = second_reg;
    assign out_box_left    = left_reg;
    assign out_box_right   = right_reg;
    assign out_box_top     = top_reg;
    assign out_box_bottom  = bottom_reg;

endmodule

### hdl/bouncing_sprite_collision_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bouncing_sprite_collision_engine
// Sprite table with bounce movement and pairwise bounding box collision test.
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one word per command: tuser selects load (0) or tick (1)
//   a load writes one sprite slot and returns nothing
//   a tick moves every enabled sprite, then tests every pair
//   i<j (through the two table read ports) and sends one
//   m_axis word per overlapping pair of enabled sprites, at most 28, then a closing word with
//   tlast high and tuser low
//   s_axis_tready is high only between ticks; a new command is taken while
//   the closing word still waits in the output register
//   a stalled receiver holds the pair walk at the pending hit
//   cfg_we writes field width (index 0) or field height (index 1); write
//   only between ticks
//   reset: all slots empty, field 640 x 480, output empty
// ----------------------------------------------------------------------------
module bouncing_sprite_collision_engine import bsce_pkg::*; #(
    parameter int SPRITE_COUNT = 8,
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [FIELD_W-1:0]    cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // slot[2:0], pos_x[14:3], pos_y[26:15], vel_x[33:27], vel_y[40:34],
    // diameter[47:41], enable[48], zero fill
    input  logic [55:0]           s_axis_tdata,
    // op[0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // first_slot[2:0], second_slot[5:3], box_left[17:6], box_right[29:18],
    // box_top[41:30], box_bottom[53:42], zero fill
    output logic [55:0]           m_axis_tdata,
    // hit[0]
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int IDX_W = $clog2(SPRITE_COUNT);

    cmd_t                    cmd;
    stat_t                   stat;
    logic [IDX_W-1:0]        idx_a;
    logic [IDX_W-1:0]        idx_b;
    logic [SLOT_W-1:0]       first_slot;
    logic [SLOT_W-1:0]       second_slot;
    logic [OUT_COORD_W-1:0]  box_left;
    logic [OUT_COORD_W-1:0]  box_right;
    logic [OUT_COORD_W-1:0]  box_top;
    logic [OUT_COORD_W-1:0]  box_bottom;

    bsce_ctrl #(
        .SPRITE_COUNT (SPRITE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd),
        .idx_a    (idx_a),
        .idx_b    (idx_b)
    );

    bsce_dpath #(
        .SPRITE_COUNT (SPRITE_COUNT),
        .COORD_BITS   (COORD_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .in_slot         (s_axis_tdata[2:0]),
        .in_pos_x        (s_axis_tdata[14:3]),
        .in_pos_y        (s_axis_tdata[26:15]),
        .in_vel_x        (s_axis_tdata[33:27]),
        .in_vel_y        (s_axis_tdata[40:34]),
        .in_diameter     (s_axis_tdata[47:41]),
        .in_enable       (s_axis_tdata[48]),
        .cmd             (cmd),
        .idx_a           (idx_a),
        .idx_b           (idx_b),
        .stat            (stat),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_hit         (m_axis_tuser),
        .out_first_slot  (first_slot),
        .out_second_slot (second_slot),
        .out_box_left    (box_left),
        .out_box_right   (box_right),
        .out_box_top     (box_top),
        .out_box_bottom  (box_bottom),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, box_bottom, box_top, box_right, box_left,
                           second_slot, first_slot};

endmodule
